// ===== sv/tbr_pkg.sv =====
`timescale 1ns / 1ps

package tbr_pkg;

	// Video memory geometry
	localparam int MEM_DEPTH = 16384;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// Request queue between front and back, and result queue
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

	// Screen geometry
	localparam logic [7:0] SCREEN_ROWS = 8'd240;
	localparam logic [4:0] TILE_ROWS   = 5'd30;

	// Upper address bits of the sixteen background palette bytes at 0x3f00
	localparam logic [ADDR_W-5:0] PAL_PAGE = 10'h3f0;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_BG_ENABLE   = 3'd0,
		CFG_SHOW_LEFT   = 3'd1,
		CFG_NT_SELECT   = 3'd2,
		CFG_PAT_HALF    = 3'd3,
		CFG_SCROLL_X    = 3'd4,
		CFG_SCROLL_Y    = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_RENDER = 1'b1
	} op_t;

	typedef struct packed {
		logic       bg_enable;
		logic       show_left;
		logic [1:0] nt_select;
		logic       pat_half;
		logic [7:0] scroll_x;
		logic [7:0] scroll_y;   // already reduced below 240
	} cfg_t;

	typedef struct packed {
		op_t              op;
		logic [ADDR_W-1:0] addr;
		logic [7:0]       data;
		logic [4:0]       row;
		logic [4:0]       col;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  x;
		logic [7:0]  y;
		logic [23:0] rgb;
		logic        last;
	} pix_t;

	// Fixed 64-entry RGB palette
	localparam logic [23:0] COLOR_TABLE [64] = '{
		24'h545454, 24'h001E74, 24'h081090, 24'h300088,
		24'h440064, 24'h5C0030, 24'h540400, 24'h3C1800,
		24'h202A00, 24'h083A00, 24'h004000, 24'h003C00,
		24'h003200, 24'h000000, 24'h000000, 24'h000000,
		24'h989698, 24'h084CC4, 24'h3032EC, 24'h5C1EE4,
		24'h8814B0, 24'hA01464, 24'h982220, 24'h783C00,
		24'h545A00, 24'h287200, 24'h087C00, 24'h007628,
		24'h006678, 24'h000000, 24'h000000, 24'h000000,
		24'hECEEEC, 24'h4C9AEC, 24'h787CEC, 24'hB062EC,
		24'hE454EC, 24'hEC58B4, 24'hEC6A64, 24'hD48820,
		24'hA0AA00, 24'h74C400, 24'h4CD020, 24'h38CC6C,
		24'h38B4CC, 24'h3C3C3C, 24'h000000, 24'h000000,
		24'hECEEEC, 24'hA8CCEC, 24'hBCBCEC, 24'hD4B2EC,
		24'hECAEEC, 24'hECAED4, 24'hECB4B0, 24'hE4C490,
		24'hCCD278, 24'hB4DE78, 24'hA8E290, 24'h98E2B4,
		24'hA0D6E4, 24'hA0A2A0, 24'h000000, 24'h000000
	};

endpackage

// ===== sv/tile_background_renderer_top.sv =====
// Write request: handled by the back end in idle once it reaches the head of the request queue.
// Render request: 8 nametable/attribute reads, then per tile row 4 pattern reads, a drain step and
// 8 pixels (held while the result queue is full); all reads share the single video memory read port.
// First pixel of a tile reaches the result queue after the tile reads and the first row's pattern reads.
// Reset clears registers, queues and sequencer; video memory and palette copy are undefined until written.
`timescale 1ns / 1ps

module tile_background_renderer_top import tbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              mode,
	input  logic [ADDR_W-1:0] mem_addr,
	input  logic [7:0]        mem_data,
	input  logic [4:0]        tile_row,
	input  logic [4:0]        tile_col,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        pixel_x,
	output logic [7:0]        pixel_y,
	output logic [23:0]       pixel_rgb,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;
	pix_t pix;
	logic pix_push;
	logic out_full;
	pix_t head;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BG_ENABLE: cfg_q.bg_enable <= cfg_data[0];
				CFG_SHOW_LEFT: cfg_q.show_left <= cfg_data[0];
				CFG_NT_SELECT: cfg_q.nt_select <= cfg_data[1:0];
				CFG_PAT_HALF:  cfg_q.pat_half  <= cfg_data[0];
				CFG_SCROLL_X:  cfg_q.scroll_x  <= cfg_data;
				CFG_SCROLL_Y: begin
					cfg_q.scroll_y <= (cfg_data >= SCREEN_ROWS) ? cfg_data - SCREEN_ROWS
						: cfg_data;
				end
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	tbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.mem_addr  (mem_addr),
		.mem_data  (mem_data),
		.tile_row  (tile_row),
		.tile_col  (tile_col),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	tbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg_q),
		.out_full  (out_full),
		.pix       (pix),
		.pix_push  (pix_push)
	);

	tbr_out_fifo u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (pix_push),
		.wr_pix (pix),
		.full   (out_full),
		.empty  (empty),
		.pop    (pop),
		.rd_pix (head)
	);

	assign pixel_x   = head.x;
	assign pixel_y   = head.y;
	assign pixel_rgb = head.rgb;
	assign last      = head.last;

endmodule

// ===== sv/tbr_front.sv =====
`timescale 1ns / 1ps

module tbr_front import tbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              mode,
	input  logic [ADDR_W-1:0] mem_addr,
	input  logic [7:0]        mem_data,
	input  logic [4:0]        tile_row,
	input  logic [4:0]        tile_col,
	input  cfg_t              cfg,
	output cmd_t              cmd,
	output logic              cmd_valid,
	input  logic              cmd_pop
);

	cmd_t                 cmd_mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W:0]   count_q;
	logic                 accept;
	logic                 keep;
	logic                 store;
	logic                 take;
	cmd_t                 cmd_new;

	assign full      = (count_q == (CMD_PTR_W+1)'(CMD_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign accept    = push && !full;
	assign take      = cmd_pop && cmd_valid;

	// Classify: drop render requests that can give no pixels
	assign keep = (mode == OP_WRITE) ||
		(cfg.bg_enable && (tile_row < TILE_ROWS) && ((tile_col != '0) || cfg.show_left));
	assign store = accept && keep;

	always_comb begin
		cmd_new.op   = op_t'(mode);
		cmd_new.addr = mem_addr;
		cmd_new.data = mem_data;
		cmd_new.row  = tile_row;
		cmd_new.col  = tile_col;
	end

	// Hold queued requests
	always_ff @(posedge clk) begin
		if (store) begin
			cmd_mem_q[wr_ptr_q] <= cmd_new;
		end
	end

	assign cmd = cmd_mem_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (store) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({store, take})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/tbr_back.sv =====
`timescale 1ns / 1ps

module tbr_back import tbr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_pop,
	input  cfg_t cfg,
	input  logic out_full,
	output pix_t pix,
	output logic pix_push
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_TILE = 4'b0010,
		S_ROW  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t            state_q;
	logic [2:0]        cnt_q;
	logic [2:0]        px_q;
	logic [2:0]        py_q;
	logic [4:0]        row_q;
	logic [4:0]        col_q;

	// Per tile: nametable entry and attribute bits for each wrap variant
	logic [7:0]        ent_q  [4];
	logic [1:0]        attr_q [4];
	// Per tile row: pattern bytes indexed by {horizontal wrap, plane}
	logic [7:0]        pat_q  [4];
	// Copy of the sixteen background palette bytes
	logic [5:0]        pal_q  [16];

	logic [7:0]        vram_q [MEM_DEPTH];
	logic [7:0]        rdata_q;
	logic              rd_vld_s1;
	logic              rd_tile_s1;
	logic [2:0]        rd_idx_s1;

	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] rd_addr;
	logic [1:0]        nt_tile;
	logic [7:0]        ys;
	logic [7:0]        xs;
	logic              yf;
	logic              xf;
	logic [7:0]        y_val;
	logic [7:0]        x_val;
	logic [7:0]        row_ent;
	logic [2:0]        bit_idx;
	logic [1:0]        bp;
	logic [3:0]        pal_idx;
	logic [2:0]        attr_sh;
	logic [7:0]        attr_byte;

	// Scroll and wrap for the current pixel
	assign ys      = {row_q, py_q};
	assign xs      = {col_q, px_q};
	assign yf      = (ys < cfg.scroll_y);
	assign xf      = (xs < cfg.scroll_x);
	assign y_val   = ys - cfg.scroll_y + (yf ? SCREEN_ROWS : 8'd0);
	assign x_val   = xs - cfg.scroll_x;

	// Read address per phase
	assign nt_tile = cfg.nt_select ^ cnt_q[1:0];
	assign row_ent = ent_q[{yf, cnt_q[1]}];

	always_comb begin
		rd_addr = '0;
		unique case (state_q)
			S_TILE: begin
				if (!cnt_q[2]) begin
					rd_addr = {2'b10, nt_tile, row_q, col_q};
				end else begin
					rd_addr = {2'b10, nt_tile, 4'hf, row_q[4:2], col_q[4:2]};
				end
			end
			S_ROW: begin
				rd_addr = {1'b0, cfg.pat_half, row_ent, cnt_q[0], py_q};
			end
			default: rd_addr = '0;
		endcase
	end

	assign mem_re  = (state_q == S_TILE) || ((state_q == S_ROW) && (cnt_q != 3'd4));
	assign mem_we  = (state_q == S_IDLE) && cmd_valid && (cmd.op == OP_WRITE);
	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	// Video memory: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			vram_q[cmd.addr] <= cmd.data;
		end
		if (mem_re) begin
			rdata_q <= vram_q[rd_addr];
		end
	end

	// Mirror palette writes
	always_ff @(posedge clk) begin
		if (mem_we && (cmd.addr[ADDR_W-1:4] == PAL_PAGE)) begin
			pal_q[cmd.addr[3:0]] <= cmd.data[5:0];
		end
	end

	// Capture fetched bytes
	assign attr_sh   = {row_q[1], col_q[1], 1'b0};
	assign attr_byte = rdata_q >> attr_sh;

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_tile_s1) begin
				if (!rd_idx_s1[2]) begin
					ent_q[rd_idx_s1[1:0]] <= rdata_q;
				end else begin
					attr_q[rd_idx_s1[1:0]] <= attr_byte[1:0];
				end
			end else begin
				pat_q[rd_idx_s1[1:0]] <= rdata_q;
			end
		end
	end

	// Latch tile coordinates
	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.op == OP_RENDER)) begin
			row_q <= cmd.row;
			col_q <= cmd.col;
		end
	end

	// Pixel colour
	assign bit_idx = ~px_q;
	assign bp      = {pat_q[{xf, 1'b1}][bit_idx], pat_q[{xf, 1'b0}][bit_idx]};
	assign pal_idx = (bp == 2'b00) ? 4'd0 : {attr_q[{yf, xf}], bp};

	always_comb begin
		pix.x    = x_val;
		pix.y    = y_val;
		pix.rgb  = COLOR_TABLE[pal_q[pal_idx]];
		pix.last = (px_q == 3'd7) && (py_q == 3'd7);
	end

	assign pix_push = (state_q == S_EMIT) && !out_full;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			px_q       <= '0;
			py_q       <= '0;
			rd_vld_s1  <= 1'b0;
			rd_tile_s1 <= 1'b0;
			rd_idx_s1  <= '0;
		end else begin
			rd_vld_s1  <= mem_re;
			rd_tile_s1 <= (state_q == S_TILE);
			rd_idx_s1  <= cnt_q;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid && (cmd.op == OP_RENDER)) begin
						cnt_q   <= '0;
						py_q    <= '0;
						state_q <= S_TILE;
					end
				end
				S_TILE: begin
					if (cnt_q == 3'd7) begin
						cnt_q   <= '0;
						state_q <= S_ROW;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROW: begin
					if (cnt_q == 3'd4) begin
						cnt_q   <= '0;
						px_q    <= '0;
						state_q <= S_EMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (!out_full) begin
						px_q <= px_q + 1'b1;
						if (px_q == 3'd7) begin
							if (py_q == 3'd7) begin
								state_q <= S_IDLE;
							end else begin
								py_q    <= py_q + 1'b1;
								cnt_q   <= '0;
								state_q <= S_ROW;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/tbr_out_fifo.sv =====
`timescale 1ns / 1ps

module tbr_out_fifo import tbr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  pix_t wr_pix,
	output logic full,
	output logic empty,
	input  logic pop,
	output pix_t rd_pix
);

	pix_t                 buf_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_PTR_W:0]   count_q;
	logic                 put;
	logic                 take;

	assign full   = (count_q == (OUT_PTR_W+1)'(OUT_DEPTH));
	assign empty  = (count_q == '0);
	assign put    = wr_en && !full;
	assign take   = pop && !empty;
	assign rd_pix = buf_q[rd_ptr_q];

	// Hold waiting pixels
	always_ff @(posedge clk) begin
		if (put) begin
			buf_q[wr_ptr_q] <= wr_pix;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (put) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({put, take})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/tbr_checker.sv =====
`timescale 1ns / 1ps

module tbr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  pixel_x,
	input logic [7:0]  pixel_y,
	input logic [23:0] pixel_rgb,
	input logic        last,
	input logic        cfg_ready
);

	// Both queues drain on reset
	a_reset_clear: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("queues not clear during reset");

	// A waiting pixel holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(pixel_rgb) && $stable(last))
		else $error("waiting pixel changed or vanished");

	// Wrapped screen row stays on the visible screen
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pixel_y < 8'd240)
		else $error("pixel row beyond screen");

	// Configuration writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind tile_background_renderer_top tbr_checker u_chk (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	import tbr_pkg::*;

	localparam int IDLE_PCT      = 32;
	localparam int QUIET_CYCLES  = 600;
	localparam int HOLD_CYCLES   = 800;
	localparam int PHASE_ITEMS   = 45;
	localparam int RANDOM_PHASES = 6;
	localparam longint RUN_LIMIT_NS = 64'd20_000_000;

	// Indexes past the last register; the block must ignore them
	localparam logic [2:0] CFG_SPARE_A = 3'd6;
	localparam logic [2:0] CFG_SPARE_B = 3'd7;

	// Tile positions that renders use; their nametable entries hold tile 00 or ff only,
	// so every byte a render reads has been filled beforehand
	localparam int NUM_POS = 12;
	localparam logic [4:0] POS_ROW [NUM_POS] = '{
		5'd0, 5'd0, 5'd29, 5'd0, 5'd29, 5'd15, 5'd7, 5'd3, 5'd0, 5'd29, 5'd14, 5'd5
	};
	localparam logic [4:0] POS_COL [NUM_POS] = '{
		5'd0, 5'd1, 5'd31, 5'd31, 5'd0, 5'd16, 5'd7, 5'd9, 5'd12, 5'd2, 5'd17, 5'd5
	};

	// Predicts the pixel stream of each render request from a mirror of video memory
	class tile_scoreboard;
		localparam int NT_BASE     = 'h2000;
		localparam int NT_STRIDE   = 'h0400;
		localparam int ATTR_OFFSET = 'h03c0;
		localparam int PAL_BASE    = 'h3f00;
		localparam int MAX_PRINTS  = 100;

		bit [7:0] vram [MEM_DEPTH];
		bit       bg_on;
		bit       left_on;
		bit [1:0] nt_sel;
		bit       pat_hi;
		bit [7:0] scroll_x;
		bit [7:0] scroll_y;
		pix_t     expected_pixels [$];
		int       errors;

		// Print one line per mismatch; keep the log short when things go badly wrong
		task report(string msg);
			if (errors < MAX_PRINTS)
				$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		function void set_register(logic [2:0] idx, logic [7:0] value);
			case (idx)
				CFG_BG_ENABLE: bg_on    = value[0];
				CFG_SHOW_LEFT: left_on  = value[0];
				CFG_NT_SELECT: nt_sel   = value[1:0];
				CFG_PAT_HALF:  pat_hi   = value[0];
				CFG_SCROLL_X:  scroll_x = value;
				CFG_SCROLL_Y:  scroll_y = value;
				default: ;
			endcase
		endfunction

		// Work out the 64 pixels of one tile, row by row
		function void predict_tile(int row, int col);
			int   sy;
			int   nt;
			int   xs;
			int   ys;
			int   x;
			int   y;
			int   base;
			int   idx;
			int   line;
			int   bp;
			int   attr;
			int   pal;
			int   n;
			pix_t p;
			if (!bg_on || row >= int'(TILE_ROWS))
				return;
			if (col == 0 && !left_on)
				return;
			sy = int'(scroll_y) % int'(SCREEN_ROWS);
			n  = 0;
			for (int py = 0; py < 8; py++) begin
				for (int px = 0; px < 8; px++) begin
					nt = nt_sel;
					xs = col * 8 + px;
					ys = row * 8 + py;
					if (xs < int'(scroll_x)) begin
						x  = xs + 256 - int'(scroll_x);
						nt = nt ^ 1;
					end else begin
						x = xs - int'(scroll_x);
					end
					if (ys < sy) begin
						y  = ys + int'(SCREEN_ROWS) - sy;
						nt = nt ^ 2;
					end else begin
						y = ys - sy;
					end
					base = NT_BASE + nt * NT_STRIDE;
					idx  = int'(vram[base + row * 32 + col]) + (pat_hi ? 256 : 0);
					line = idx * 16 + py;
					bp   = int'(vram[line][7 - px]) | (int'(vram[line + 8][7 - px]) << 1);
					attr = vram[base + ATTR_OFFSET + (row / 4) * 8 + col / 4];
					if ((row & 3) > 1)
						attr = attr >> 4;
					if ((col & 3) > 1)
						attr = attr >> 2;
					pal = (bp == 0) ? 0 : (((attr << 2) | bp) & 'hf);
					p.x    = x[7:0];
					p.y    = y[7:0];
					p.rgb  = COLOR_TABLE[vram[PAL_BASE + pal][5:0]];
					p.last = (n == 63);
					expected_pixels.push_back(p);
					n++;
				end
			end
		endfunction

		function void note_request(op_t op, logic [ADDR_W-1:0] addr, logic [7:0] data,
				logic [4:0] row, logic [4:0] col);
			if (op == OP_WRITE)
				vram[addr] = data;
			else
				predict_tile(row, col);
		endfunction

		task check_pixel(pix_t got);
			pix_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("pixel with nothing expected: x=%0d y=%0d rgb=%06h",
					got.x, got.y, got.rgb));
				return;
			end
			want = expected_pixels.pop_front();
			if (got.x !== want.x)
				report($sformatf("pixel_x %0d, want %0d", got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("pixel_y %0d, want %0d", got.y, want.y));
			if (got.rgb !== want.rgb)
				report($sformatf("pixel_rgb %06h, want %06h at x=%0d y=%0d",
					got.rgb, want.rgb, want.x, want.y));
			if (got.last !== want.last)
				report($sformatf("last %0b, want %0b", got.last, want.last));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic              mode;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]        mem_data;
	logic [4:0]        tile_row;
	logic [4:0]        tile_col;
	logic              empty;
	logic              pop;
	logic [7:0]        pixel_x;
	logic [7:0]        pixel_y;
	logic [23:0]       pixel_rgb;
	logic              last;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [2:0]        cfg_index;
	logic [7:0]        cfg_data;

	logic steady;
	logic hold_req;
	logic hold_results;

	tile_scoreboard sb = new();

	tile_background_renderer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.mem_addr  (mem_addr),
		.mem_data  (mem_data),
		.tile_row  (tile_row),
		.tile_col  (tile_col),
		.empty     (empty),
		.pop       (pop),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.pixel_rgb (pixel_rgb),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic bit roll_idle();
		return !steady && ($urandom_range(99) < IDLE_PCT);
	endfunction

	// Nametable entry and attribute byte of a listed position in nametable nt
	function automatic logic [ADDR_W-1:0] entry_addr(int nt, int pos);
		return ADDR_W'('h2000 + nt * 'h400 + int'(POS_ROW[pos]) * 32 + int'(POS_COL[pos]));
	endfunction

	function automatic logic [ADDR_W-1:0] attr_addr(int nt, int pos);
		return ADDR_W'('h2000 + nt * 'h400 + 'h3c0 + (int'(POS_ROW[pos]) / 4) * 8
			+ int'(POS_COL[pos]) / 4);
	endfunction

	// Pattern byte k of tile 00 (tile == 0) or tile ff in the given pattern half
	function automatic logic [ADDR_W-1:0] pattern_addr(int half, int tile, int k);
		return ADDR_W'(half * 'h1000 + ((tile != 0) ? 'hff : 0) * 16 + k);
	endfunction

	function automatic logic [7:0] tile_number();
		return {8{1'($urandom_range(1))}};
	endfunction

	// Offer one request, idling first at random; hold it until taken
	task automatic send_item(op_t op, logic [ADDR_W-1:0] addr, logic [7:0] data,
			logic [4:0] row, logic [4:0] col);
		while (roll_idle()) begin
			@(negedge clk);
			push = 1'b0;
		end
		@(negedge clk);
		push     = 1'b1;
		mode     = op;
		mem_addr = addr;
		mem_data = data;
		tile_row = row;
		tile_col = col;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_request(op, addr, data, row, col);
	endtask

	task automatic write_byte(logic [ADDR_W-1:0] addr, logic [7:0] data);
		send_item(OP_WRITE, addr, data, 5'($urandom_range(31)), 5'($urandom_range(31)));
	endtask

	task automatic render_tile(logic [4:0] row, logic [4:0] col);
		send_item(OP_RENDER, ADDR_W'($urandom_range(MEM_DEPTH - 1)), 8'($urandom_range(255)),
			row, col);
	endtask

	task automatic write_register(logic [2:0] idx, logic [7:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_register(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Fill every byte a render of a listed position can touch
	task automatic fill_memory();
		for (int p = 0; p < NUM_POS; p++) begin
			for (int nt = 0; nt < 4; nt++) begin
				write_byte(entry_addr(nt, p), tile_number());
				write_byte(attr_addr(nt, p), 8'($urandom_range(255)));
			end
		end
		for (int h = 0; h < 2; h++)
			for (int t = 0; t < 2; t++)
				for (int k = 0; k < 16; k++)
					write_byte(pattern_addr(h, t, k), 8'($urandom_range(255)));
		for (int a = 'h3f00; a < 'h3f10; a++)
			write_byte(ADDR_W'(a), 8'($urandom_range(255)));
	endtask

	// Stop offering, let every expected pixel arrive, then let the back end go quiet
	task automatic wait_idle();
		@(negedge clk);
		push = 1'b0;
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES)
			@(posedge clk);
	endtask

	// Random request: renders, mostly of listed tiles, and writes mostly aimed at the areas a render reads
	task automatic random_item();
		int sel;
		int p;
		sel = $urandom_range(99);
		p   = $urandom_range(NUM_POS - 1);
		if (sel < 55) begin
			if ($urandom_range(9) == 0)
				render_tile(5'(30 + $urandom_range(1)), 5'($urandom_range(31)));
			else
				render_tile(POS_ROW[p], POS_COL[p]);
		end else begin
			case ($urandom_range(4))
				0: write_byte(ADDR_W'('h3f00 + $urandom_range(15)), 8'($urandom_range(255)));
				1: write_byte(entry_addr($urandom_range(3), p), tile_number());
				2: write_byte(attr_addr($urandom_range(3), p), 8'($urandom_range(255)));
				3: write_byte(pattern_addr($urandom_range(1), $urandom_range(1),
					$urandom_range(15)), 8'($urandom_range(255)));
				default: write_byte(ADDR_W'('h3000 + $urandom_range('h0eff)),
					8'($urandom_range(255)));
			endcase
		end
	endtask

	// Drain the result side, idling at random; hold off entirely while asked
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop = !hold_results && !roll_idle();
			@(posedge clk);
			if (pop && !empty)
				sb.check_pixel('{x: pixel_x, y: pixel_y, rgb: pixel_rgb, last: last});
		end
	end

	// Long receiver hold-off, counted here so the sender keeps pushing meanwhile
	initial begin
		hold_results = 1'b0;
		wait (hold_req);
		hold_results = 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		hold_results = 1'b0;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		mode      = OP_WRITE;
		mem_addr  = '0;
		mem_data  = '0;
		tile_row  = '0;
		tile_col  = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		steady    = 1'b0;
		hold_req  = 1'b0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill nametables, attributes, pattern bytes and palette that renders touch
		fill_memory();

		// Background off: renders give nothing
		render_tile(5'd5, 5'd5);
		render_tile(5'd0, 5'd0);
		wait_idle();

		// Spare register indexes written, left column hidden, rows below the screen, corners of the map
		write_register(CFG_BG_ENABLE, 8'd1);
		write_register(CFG_SPARE_A, 8'hff);
		write_register(CFG_SPARE_B, 8'h00);
		render_tile(5'd0, 5'd0);
		render_tile(5'd30, 5'd3);
		render_tile(5'd31, 5'd31);
		render_tile(5'd0, 5'd1);
		render_tile(5'd29, 5'd31);
		render_tile(5'd14, 5'd17);
		wait_idle();

		// Widest scroll, far nametable, upper pattern half
		write_register(CFG_SHOW_LEFT, 8'd1);
		write_register(CFG_NT_SELECT, 8'd3);
		write_register(CFG_PAT_HALF, 8'd1);
		write_register(CFG_SCROLL_X, 8'd255);
		write_register(CFG_SCROLL_Y, 8'd239);
		render_tile(5'd0, 5'd0);
		render_tile(5'd29, 5'd31);
		render_tile(5'd0, 5'd31);
		render_tile(5'd29, 5'd0);
		render_tile(5'd15, 5'd16);
		write_byte(ADDR_W'('h3f00), 8'hff);
		render_tile(5'd7, 5'd7);
		wait_idle();

		// Vertical scroll at and past the screen height wraps round
		write_register(CFG_SCROLL_Y, 8'd240);
		write_register(CFG_SCROLL_X, 8'd0);
		render_tile(5'd3, 5'd9);
		wait_idle();
		write_register(CFG_SCROLL_Y, 8'd255);
		write_register(CFG_NT_SELECT, 8'd0);
		render_tile(5'd0, 5'd12);
		render_tile(5'd29, 5'd2);
		wait_idle();

		// Random phases, each under its own settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			steady = (p == 0);
			write_register(CFG_BG_ENABLE, (p == 2 || $urandom_range(5) != 0) ? 8'd1 : 8'd0);
			write_register(CFG_SHOW_LEFT, (p == 2) ? 8'd1 : 8'($urandom_range(1)));
			write_register(CFG_NT_SELECT, 8'($urandom_range(3)));
			write_register(CFG_PAT_HALF, 8'($urandom_range(1)));
			write_register(CFG_SCROLL_X, 8'($urandom_range(255)));
			write_register(CFG_SCROLL_Y, 8'($urandom_range(255)));
			if (p == 2)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS)
				random_item();
			wait_idle();
		end

		if (sb.errors == 0 && sb.expected_pixels.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
